// ===== rtl/kcl_pkg.sv =====
// Shared types, constants and key decode for the keypad code lock.
package kcl_pkg;

	localparam int CODE_DIGITS = 4;
	localparam int POS_W       = $clog2(CODE_DIGITS + 1);
	localparam int CFG_W       = 16;

	// register indexes on the configuration port
	localparam logic [1:0] CFG_SECRET   = 2'd0;
	localparam logic [1:0] CFG_DEBOUNCE = 2'd1;
	localparam logic [1:0] CFG_TIMEOUT  = 2'd2;

	localparam logic [3:0] KEY_STAR = 4'd10;
	localparam logic [3:0] KEY_HASH = 4'd11;
	localparam logic [3:0] KEY_NONE = 4'd15;
	localparam logic [3:0] KEY_MAX_DIGIT = 4'd9;

	localparam logic OP_TICK  = 1'b0;
	localparam logic OP_PRESS = 1'b1;

	typedef enum logic [2:0] {
		ACT_NONE    = 3'd0,
		ACT_IDLE    = 3'd1,
		ACT_FIRST   = 3'd2,
		ACT_ECHO    = 3'd3,
		ACT_SUCCESS = 3'd4,
		ACT_WRONG   = 3'd5
	} act_t;

	typedef struct packed {
		logic       operation;
		logic [1:0] key_row;
		logic [1:0] key_column;
	} kcl_item_t;

	typedef struct packed {
		act_t       action;
		logic [3:0] digit;
		logic       toggle;
		logic       ignored;
	} kcl_result_t;

	typedef struct packed {
		logic [CFG_W-1:0] secret_code;
		logic [CFG_W-1:0] debounce_ticks;
		logic [CFG_W-1:0] timeout_ticks;
	} kcl_cfg_t;

	// 4x3 keypad: 1 2 3 / 4 5 6 / 7 8 9 / * 0 #, column three is no key
	function automatic logic [3:0] key_lookup(input logic [1:0] row, input logic [1:0] col);
		logic [3:0] key;
		key = KEY_NONE;
		if (col != 2'd3) begin
			if (row == 2'd3) begin
				unique case (col)
					2'd0:    key = KEY_STAR;
					2'd1:    key = 4'd0;
					default: key = KEY_HASH;
				endcase
			end else begin
				key = 4'({2'b00, row} * 4'd3 + {2'b00, col} + 4'd1);
			end
		end
		return key;
	endfunction

endpackage

// ===== rtl/keypad_code_lock_top.sv =====
// Top level of the keypad code lock: config registers, input register, result register.
// Keypad code lock. Each input word is a one-millisecond tick or a key press and gives exactly
// one result word. One word is taken per clock while in_stall is low; a result word passes the
// input register, then the state update in kcl_core, then the result register. Configuration
// writes take effect at the next edge and belong in idle periods. After reset the code is 2539,
// the lockout 200 ticks, the timeout 5000 ticks.
module keypad_code_lock_top
	import kcl_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_write,
	input  logic [1:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic             operation,
	input  logic [1:0]       key_row,
	input  logic [1:0]       key_column,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [2:0]       display_action,
	output logic [3:0]       shown_digit,
	output logic             door_toggle,
	output logic             press_ignored
);

	kcl_cfg_t    cfg_q;
	logic        valid_s1;
	kcl_item_t   item_s1;
	kcl_result_t result;
	kcl_result_t result_s2;
	logic        valid_s2;
	logic        advance;
	logic        step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.secret_code    <= 16'h2539;
			cfg_q.debounce_ticks <= 16'd200;
			cfg_q.timeout_ticks  <= 16'd5000;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_SECRET:   cfg_q.secret_code    <= cfg_data;
				CFG_DEBOUNCE: cfg_q.debounce_ticks <= cfg_data;
				CFG_TIMEOUT:  cfg_q.timeout_ticks  <= cfg_data;
				default: ;
			endcase
		end
	end

	// result register frees up when empty or when its word is taken
	assign advance  = !valid_s2 || !out_stall;
	assign step     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			item_s1 <= '{operation: operation, key_row: key_row, key_column: key_column};
		end
	end

	kcl_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.cfg    (cfg_q),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			result_s2 <= result;
		end
	end

	assign out_valid      = valid_s2;
	assign display_action = result_s2.action;
	assign shown_digit    = result_s2.digit;
	assign door_toggle    = result_s2.toggle;
	assign press_ignored  = result_s2.ignored;

`ifndef ASSERT_OFF
	a_stall_needs_word: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && valid_s2 && out_stall)
		else $error("input stalled without a waiting word");

	a_step_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> valid_s2)
		else $error("processed word did not reach the result register");

	a_toggle_on_success: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && door_toggle |-> display_action == ACT_SUCCESS)
		else $error("door toggle without success");

	a_ignored_is_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && press_ignored |-> display_action == ACT_NONE && !door_toggle)
		else $error("ignored press produced an action");
`endif

endmodule

// ===== rtl/kcl_core.sv =====
// Lock state: entry phase, digits, debounce and timeout counters, and the result of one word.
module kcl_core
	import kcl_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  kcl_item_t   item,
	input  kcl_cfg_t    cfg,
	output kcl_result_t result
);

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_ENTER = 2'd1,
		PH_WAIT  = 2'd2,
		PH_SHOWN = 2'd3
	} phase_t;

	phase_t            phase_q, phase_n;
	logic [POS_W-1:0]  pos_q, pos_n;
	logic [3:0]        digits_q [CODE_DIGITS];
	logic [3:0]        digits_n [CODE_DIGITS];
	logic              enabled_q, enabled_n;
	logic [CFG_W-1:0]  deb_q, deb_n;
	logic [CFG_W-1:0]  tmo_q, tmo_n;
	logic [3:0]        key;
	logic              match;
	logic [CFG_W-1:0]  code_shift;

	assign key = key_lookup(item.key_row, item.key_column);

	always_comb begin
		match = 1'b1;
		code_shift = '0;
		for (int i = 0; i < CODE_DIGITS; i++) begin
			// nibbles beyond the register read as zero
			code_shift = cfg.secret_code >> (4 * (CODE_DIGITS - 1 - i));
			if (code_shift[3:0] != digits_q[i])
				match = 1'b0;
		end
	end

	always_comb begin
		phase_n   = phase_q;
		pos_n     = pos_q;
		digits_n  = digits_q;
		enabled_n = enabled_q;
		deb_n     = deb_q;
		tmo_n     = tmo_q;
		result    = '{action: ACT_NONE, digit: 4'd0, toggle: 1'b0, ignored: 1'b0};

		if (item.operation == OP_TICK) begin
			if (deb_q != '0) begin
				deb_n = deb_q - 1'b1;
				if (deb_n == '0)
					enabled_n = 1'b1;
			end
			if (tmo_q != '0) begin
				tmo_n = tmo_q - 1'b1;
				if (tmo_n == '0) begin
					phase_n = PH_IDLE;
					pos_n   = '0;
					for (int i = 0; i < CODE_DIGITS; i++)
						digits_n[i] = 4'd0;
					result.action = ACT_IDLE;
				end
			end
		end else if (!enabled_q) begin
			result.ignored = 1'b1;
		end else begin
			if (cfg.debounce_ticks != '0) begin
				enabled_n = 1'b0;
				deb_n     = cfg.debounce_ticks;
			end
			tmo_n = (cfg.timeout_ticks == '0) ? CFG_W'(1) : cfg.timeout_ticks;

			if ((phase_q == PH_IDLE || phase_q == PH_ENTER) && key <= KEY_MAX_DIGIT) begin
				for (int i = 0; i < CODE_DIGITS; i++)
					if (pos_q == POS_W'(i))
						digits_n[i] = key;
				pos_n = pos_q + 1'b1;
				// in idle the position is zero, so the first digit is the key itself
				result.action = (phase_q == PH_IDLE) ? ACT_FIRST : ACT_ECHO;
				result.digit  = key;
				phase_n = (pos_n >= POS_W'(CODE_DIGITS)) ? PH_WAIT : PH_ENTER;
			end else if (phase_q == PH_WAIT && key == KEY_HASH) begin
				phase_n = PH_SHOWN;
				if (match) begin
					result.action = ACT_SUCCESS;
					result.toggle = 1'b1;
				end else begin
					result.action = ACT_WRONG;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			pos_q     <= '0;
			enabled_q <= 1'b1;
			deb_q     <= '0;
			tmo_q     <= '0;
			for (int i = 0; i < CODE_DIGITS; i++)
				digits_q[i] <= 4'd0;
		end else if (step) begin
			phase_q   <= phase_n;
			pos_q     <= pos_n;
			enabled_q <= enabled_n;
			deb_q     <= deb_n;
			tmo_q     <= tmo_n;
			digits_q  <= digits_n;
		end
	end

endmodule

// ===== sim/keypad_code_lock_tb.sv =====
// Self-checking testbench for keypad_code_lock_top: directed table, then random entry sequences.
module testbench
	import kcl_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int PERIOD     = 12;
	localparam int RESET_ROWS = 3;
	localparam int DIR_ROWS   = 25;
	localparam int SHOW_MAX   = 10;
	localparam int TICK_CAP   = 40;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_ENTRY = 2'd1,
		PH_HASH  = 2'd2,
		PH_SHOWN = 2'd3
	} phase_t;

	typedef struct packed {
		kcl_item_t   w;
		logic        given;
		kcl_result_t res;
	} dir_row_t;

	localparam kcl_result_t R_NONE    = {ACT_NONE, 4'd0, 1'b0, 1'b0};
	localparam kcl_result_t R_IGNORED = {ACT_NONE, 4'd0, 1'b0, 1'b1};
	localparam kcl_result_t R_IDLE    = {ACT_IDLE, 4'd0, 1'b0, 1'b0};
	localparam kcl_result_t R_OPEN    = {ACT_SUCCESS, 4'd0, 1'b1, 1'b0};
	localparam kcl_result_t R_WRONG   = {ACT_WRONG, 4'd0, 1'b0, 1'b0};

	// key code per {row, column}, column three is no key
	localparam logic [63:0] KEYPAD = {
		KEY_NONE, KEY_HASH, 4'd0, KEY_STAR,
		KEY_NONE, 4'd9, 4'd8, 4'd7,
		KEY_NONE, 4'd6, 4'd5, 4'd4,
		KEY_NONE, 4'd3, 4'd2, 4'd1
	};

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_write;
	logic [1:0]       cfg_index;
	logic [CFG_W-1:0] cfg_data;
	logic             in_valid;
	logic             in_stall;
	logic             operation;
	logic [1:0]       key_row;
	logic [1:0]       key_column;
	logic             out_valid;
	logic             out_stall;
	logic [2:0]       display_action;
	logic [3:0]       shown_digit;
	logic             door_toggle;
	logic             press_ignored;

	keypad_code_lock_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.operation(operation),
		.key_row(key_row),
		.key_column(key_column),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.display_action(display_action),
		.shown_digit(shown_digit),
		.door_toggle(door_toggle),
		.press_ignored(press_ignored)
	);

	always #(PERIOD / 2) clk = ~clk;

	// lock state mirror
	kcl_cfg_t         lock_cfg;
	phase_t           entry_phase;
	logic [POS_W-1:0] entry_pos;
	logic [3:0]       entry_digits [CODE_DIGITS];
	logic             presses_on;
	logic [CFG_W-1:0] lockout_left;
	logic [CFG_W-1:0] idle_left;

	kcl_result_t due_responses [$];
	int          fail_count = 0;
	int          shown_count = 0;
	int          words_taken = 0;
	logic        burst = 1'b0;

	dir_row_t    dir_tab [DIR_ROWS];

	function automatic void clear_entry();
		entry_phase = PH_IDLE;
		entry_pos = '0;
		for (int i = 0; i < CODE_DIGITS; i++)
			entry_digits[i] = 4'd0;
	endfunction

	function automatic kcl_result_t next_response(input kcl_item_t w);
		kcl_result_t r;
		logic [3:0]  key;
		logic        match;
		r.action = ACT_NONE;
		r.digit = 4'd0;
		r.toggle = 1'b0;
		r.ignored = 1'b0;
		if (w.operation == OP_TICK) begin
			if (lockout_left != 0) begin
				lockout_left = lockout_left - 1'b1;
				if (lockout_left == 0)
					presses_on = 1'b1;
			end
			if (idle_left != 0) begin
				idle_left = idle_left - 1'b1;
				if (idle_left == 0) begin
					clear_entry();
					r.action = ACT_IDLE;
				end
			end
		end else if (!presses_on) begin
			r.ignored = 1'b1;
		end else begin
			if (lock_cfg.debounce_ticks != 0) begin
				presses_on = 1'b0;
				lockout_left = lock_cfg.debounce_ticks;
			end
			idle_left = (lock_cfg.timeout_ticks == 0) ? 16'd1 : lock_cfg.timeout_ticks;
			key = KEYPAD[{w.key_row, w.key_column} * 4 +: 4];
			if ((entry_phase == PH_IDLE || entry_phase == PH_ENTRY) && key <= KEY_MAX_DIGIT) begin
				if (entry_pos < CODE_DIGITS)
					entry_digits[entry_pos] = key;
				entry_pos = entry_pos + 1'b1;
				r.action = (entry_phase == PH_IDLE) ? ACT_FIRST : ACT_ECHO;
				r.digit = (entry_phase == PH_IDLE) ? entry_digits[0] : key;
				entry_phase = (entry_pos >= CODE_DIGITS) ? PH_HASH : PH_ENTRY;
			end else if (entry_phase == PH_HASH && key == KEY_HASH) begin
				entry_phase = PH_SHOWN;
				match = 1'b1;
				// first digit against the top nibble
				for (int i = 0; i < CODE_DIGITS; i++)
					if (lock_cfg.secret_code[4 * (CODE_DIGITS - 1 - i) +: 4] != entry_digits[i])
						match = 1'b0;
				r.action = match ? ACT_SUCCESS : ACT_WRONG;
				r.toggle = match;
			end
		end
		return r;
	endfunction

	task automatic send_word(input kcl_item_t w, input logic given, input kcl_result_t res);
		int          gap;
		kcl_result_t pred;
		gap = burst ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= w.operation;
		key_row <= w.key_row;
		key_column <= w.key_column;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pred = next_response(w);
		due_responses.push_back(given ? res : pred);
		words_taken++;
	endtask

	task automatic press(input logic [1:0] row, input logic [1:0] col);
		send_word({OP_PRESS, row, col}, 1'b0, R_NONE);
	endtask

	task automatic press_digit(input logic [3:0] d);
		logic [3:0] k;
		if (d == 4'd0 || d > KEY_MAX_DIGIT) begin
			press(2'd3, 2'd1);
		end else begin
			k = d - 4'd1;
			press(2'(k / 4'd3), 2'(k % 4'd3));
		end
	endtask

	task automatic run_ticks(input int n);
		int c;
		c = (n > TICK_CAP) ? TICK_CAP : n;
		repeat (c)
			send_word({OP_TICK, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3))},
				1'b0, R_NONE);
	endtask

	// run up to TICK_CAP ticks against the lockout, sometimes poking a key while it runs
	task automatic settle();
		if (lock_cfg.debounce_ticks != 0 && $urandom_range(0, 5) == 0)
			press(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
		run_ticks(int'(lock_cfg.debounce_ticks) + $urandom_range(0, 1));
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (due_responses.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic load_config(input kcl_cfg_t c);
		cfg_write <= 1'b1;
		cfg_index <= CFG_SECRET;
		cfg_data <= c.secret_code;
		@(posedge clk);
		cfg_index <= CFG_DEBOUNCE;
		cfg_data <= c.debounce_ticks;
		@(posedge clk);
		cfg_index <= CFG_TIMEOUT;
		cfg_data <= c.timeout_ticks;
		@(posedge clk);
		cfg_write <= 1'b0;
		lock_cfg = c;
	endtask

	task automatic run_sequence();
		int         kind;
		int         n;
		logic       right;
		logic [3:0] d;
		burst = ($urandom_range(0, 3) == 0);
		kind = $urandom_range(0, 9);
		if (kind < 6) begin
			// full entry then '#', right code half the time
			right = $urandom_range(0, 1);
			for (int k = 0; k < CODE_DIGITS; k++) begin
				d = right ? lock_cfg.secret_code[4 * (CODE_DIGITS - 1 - k) +: 4]
					: 4'($urandom_range(0, 9));
				press_digit(d);
				settle();
			end
			if ($urandom_range(0, 3) == 0) begin
				press_digit(4'($urandom_range(0, 9)));
				settle();
			end
			press(2'd3, 2'd2);
			if ($urandom_range(0, 2) == 0) begin
				settle();
				press(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
			end
			run_ticks(int'(lock_cfg.timeout_ticks) + $urandom_range(0, 3));
		end else if (kind < 8) begin
			// broken entry, may time out halfway
			n = $urandom_range(1, 3);
			repeat (n) begin
				press_digit(4'($urandom_range(0, 9)));
				if ($urandom_range(0, 1) == 0)
					settle();
			end
			if ($urandom_range(0, 1) == 0)
				press(2'd3, 2'($urandom_range(0, 2)));
			run_ticks($urandom_range(0, int'(lock_cfg.timeout_ticks) + 2));
		end else begin
			n = $urandom_range(1, 10);
			repeat (n)
				send_word(kcl_item_t'(5'($urandom_range(0, 31))), 1'b0, R_NONE);
		end
		if ($urandom_range(0, 40) == 0)
			wait_idle();
	endtask

	function automatic logic [CFG_W-1:0] random_bcd();
		logic [CFG_W-1:0] v;
		for (int i = 0; i < CODE_DIGITS; i++)
			v[4 * i +: 4] = 4'($urandom_range(0, 9));
		return v;
	endfunction

	// result side: check each word, then stall for a random while
	initial begin : sink
		int          hold;
		int          fast_left;
		kcl_result_t want;
		hold = 0;
		fast_left = 0;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				if (due_responses.size() == 0) begin
					fail_count++;
					if (shown_count < SHOW_MAX)
						$display("%0t: unexpected word act=%0d digit=%0d door=%0b ign=%0b",
							$realtime, display_action, shown_digit, door_toggle, press_ignored);
					shown_count++;
				end else begin
					want = due_responses.pop_front();
					if (display_action !== want.action || shown_digit !== want.digit ||
						door_toggle !== want.toggle || press_ignored !== want.ignored) begin
						fail_count++;
						if (shown_count < SHOW_MAX)
							$display({"%0t: mismatch exp act=%0d digit=%0d door=%0b ign=%0b",
								" got act=%0d digit=%0d door=%0b ign=%0b"}, $realtime,
								want.action, want.digit, want.toggle, want.ignored,
								display_action, shown_digit, door_toggle, press_ignored);
						shown_count++;
					end
				end
				if (fast_left > 0) begin
					fast_left--;
					hold = 0;
				end else begin
					if ($urandom_range(0, 15) == 0)
						fast_left = $urandom_range(10, 40);
					hold = $urandom_range(0, 18);
				end
				if (hold > 0)
					out_stall <= 1'b1;
			end else if (hold > 0) begin
				hold--;
				if (hold == 0)
					out_stall <= 1'b0;
			end
		end
	end

	initial begin : stim
		kcl_cfg_t c;
		int       start;
		int       budget;
		int       k;
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = CFG_SECRET;
		cfg_data = '0;
		in_valid = 1'b0;
		operation = OP_TICK;
		key_row = 2'd0;
		key_column = 2'd0;
		lock_cfg.secret_code = 16'h2539;
		lock_cfg.debounce_ticks = 16'd200;
		lock_cfg.timeout_ticks = 16'd5000;
		clear_entry();
		presses_on = 1'b1;
		lockout_left = '0;
		idle_left = '0;

		dir_tab = '{
			{OP_TICK,  2'd3, 2'd3, 1'b1, R_NONE},
			{OP_PRESS, 2'd3, 2'd3, 1'b1, R_NONE},     // no key, still starts lockout
			{OP_PRESS, 2'd0, 2'd0, 1'b1, R_IGNORED},
			{OP_PRESS, 2'd3, 2'd0, 1'b1, R_NONE},     // '*'
			{OP_PRESS, 2'd3, 2'd2, 1'b1, R_NONE},     // '#' before any digit
			{OP_PRESS, 2'd0, 2'd1, 1'b0, R_NONE},
			{OP_PRESS, 2'd1, 2'd1, 1'b0, R_NONE},
			{OP_PRESS, 2'd0, 2'd2, 1'b0, R_NONE},
			{OP_PRESS, 2'd2, 2'd2, 1'b0, R_NONE},
			{OP_PRESS, 2'd1, 2'd0, 1'b1, R_NONE},     // digit while waiting for '#'
			{OP_PRESS, 2'd3, 2'd0, 1'b1, R_NONE},
			{OP_PRESS, 2'd3, 2'd2, 1'b1, R_OPEN},
			{OP_PRESS, 2'd3, 2'd2, 1'b1, R_NONE},     // result shown, keys dead
			{OP_PRESS, 2'd2, 2'd0, 1'b1, R_NONE},
			{OP_TICK,  2'd0, 2'd0, 1'b1, R_NONE},
			{OP_TICK,  2'd3, 2'd3, 1'b1, R_NONE},
			{OP_TICK,  2'd1, 2'd2, 1'b1, R_IDLE},
			{OP_TICK,  2'd2, 2'd1, 1'b1, R_NONE},
			{OP_PRESS, 2'd3, 2'd1, 1'b0, R_NONE},
			{OP_PRESS, 2'd2, 2'd1, 1'b0, R_NONE},
			{OP_PRESS, 2'd0, 2'd3, 1'b1, R_NONE},
			{OP_PRESS, 2'd2, 2'd1, 1'b0, R_NONE},
			{OP_PRESS, 2'd2, 2'd1, 1'b0, R_NONE},
			{OP_PRESS, 2'd3, 2'd2, 1'b1, R_WRONG},
			{OP_PRESS, 2'd0, 2'd0, 1'b1, R_NONE}
		};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_ROWS; i++) begin
			if (i == RESET_ROWS) begin
				// run out the reset lockout, then no lockout and a short timeout
				repeat (lock_cfg.debounce_ticks) send_word({OP_TICK, 2'd0, 2'd0}, 1'b0, R_NONE);
				wait_idle();
				c.secret_code = lock_cfg.secret_code;
				c.debounce_ticks = 16'd0;
				c.timeout_ticks = 16'd3;
				load_config(c);
			end
			send_word(dir_tab[i].w, dir_tab[i].given, dir_tab[i].res);
		end
		wait_idle();

		for (int p = 0; p < 8; p++) begin
			case (p)
				0: begin c = {random_bcd(), 16'd0, 16'd12}; budget = 280; end
				1: begin c = {16'h0000, 16'd1, 16'd20}; budget = 280; end
				2: begin c = {16'h9999, 16'd3, 16'd30}; budget = 280; end
				3: begin c = {16'h1A2B, 16'd2, 16'd25}; budget = 200; end
				4: begin c = {random_bcd(), 16'd4, 16'd16}; budget = 280; end
				5: begin c = {random_bcd(), 16'($urandom_range(0, 3)), 16'd0}; budget = 60; end
				6: begin c = {random_bcd(), 16'd0, 16'd1}; budget = 60; end
				default: begin c = {random_bcd(), 16'hFFFF, 16'hFFFF}; budget = 60; end
			endcase
			load_config(c);
			start = words_taken;
			while (words_taken - start < budget)
				run_sequence();
			burst = 1'b0;
			wait_idle();
		end

		k = 0;
		while (due_responses.size() != 0 && k < 2000) begin
			@(posedge clk);
			k++;
		end
		repeat (8) @(posedge clk);
		if (due_responses.size() != 0)
			fail_count++;
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin : watchdog
		#(20_000_000);
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
